// ----- rtl/rxd_pkg.sv -----
package rxd_pkg;

  // Lane geometry
  localparam int unsigned LaneCount = 8;
  localparam int unsigned LaneWidth = 32;
  localparam int unsigned LaneIdxW  = 3;
  localparam int unsigned RotLeft   = 7;

  typedef logic [LaneWidth-1:0] lane_t;
  typedef lane_t [LaneCount-1:0] lane_set_t;

  // Start words loaded after reset and after every digest
  localparam lane_set_t StartWords = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [LaneIdxW-1:0] LastWordNum = LaneIdxW'(LaneCount - 1);

  // Input transfer payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  // Output transfer payload
  typedef struct packed {
    logic [31:0]         digest_word;
    logic [LaneIdxW-1:0] word_number;
    logic                last_word;
  } out_t;

  // Handshake between the absorb stage and the digest buffer
  typedef struct packed {
    logic load;
    logic ready;
  } buf_ctrl_t;

endpackage

// ----- rtl/rxd_lane_mix.sv -----
// Absorbs one byte into all eight lanes.
module rxd_lane_mix (
  input  rxd_pkg::lane_set_t lanes_i,
  input  logic [31:0]        position_i,
  input  logic [7:0]         data_byte_i,
  output rxd_pkg::lane_set_t lanes_o,
  output logic [31:0]        position_o
);

  logic [31:0] tag;

  assign tag        = position_i + 32'd1;
  assign position_o = tag;

  // Mixing value walks through the lanes in order
  always_comb begin
    logic [31:0] mix;
    logic [31:0] x;
    mix = {24'd0, data_byte_i};
    for (int unsigned k = 0; k < rxd_pkg::LaneCount; k++) begin
      x          = lanes_i[k] ^ mix;
      x          = {x[31-rxd_pkg::RotLeft:0], x[31:32-rxd_pkg::RotLeft]};
      lanes_o[k] = x ^ tag;
      mix        = {mix[30:0], 1'b0} ^ {7'd0, mix[31:7]};
    end
  end

endmodule

// ----- rtl/rxd_digest_buf.sv -----
// Holds one finished digest and shifts it out a word per transfer.
module rxd_digest_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rxd_pkg::lane_set_t   words_i,
  input  rxd_pkg::buf_ctrl_t   ctrl_i,
  output rxd_pkg::buf_ctrl_t   ctrl_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rxd_pkg::out_t        out_data_o
);

  rxd_pkg::lane_set_t                words_q, words_d;
  logic [rxd_pkg::LaneIdxW-1:0]      cnt_q, cnt_d;
  logic                              valid_q, valid_d;
  logic                              xfer;
  logic                              last;

  assign last = (cnt_q == rxd_pkg::LastWordNum);
  assign xfer = valid_q && !out_stall_i;

  // Free now, or freeing on this transfer of the last word
  assign ctrl_o.ready = !valid_q || (xfer && last);
  assign ctrl_o.load  = ctrl_i.load;

  always_comb begin
    words_d = words_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    if (ctrl_i.load) begin
      words_d = words_i;
      cnt_d   = '0;
      valid_d = 1'b1;
    end else if (xfer) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        for (int unsigned k = 0; k < rxd_pkg::LaneCount - 1; k++) begin
          words_d[k] = words_q[k+1];
        end
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    words_q <= words_d;
  end

  assign out_valid_o            = valid_q;
  assign out_data_o.digest_word = words_q[0];
  assign out_data_o.word_number = cnt_q;
  assign out_data_o.last_word   = last;

endmodule

// ----- rtl/rotate_xor_byte_digest.sv -----
// Byte-stream digest with eight 32-bit lanes. Takes one message byte per
// cycle unless stalled; the byte is registered and absorbed into the lanes
// in the next cycle by a single pass of XOR and rotate logic. The byte
// flagged final hands the eight lanes to an output buffer and restarts the
// lanes, so the next message can start in the following cycle. The digest
// leaves as eight transfers, word 0 first, once the final byte has loaded
// the buffer. The output buffer holds one digest: a final byte stalls the
// input only while the previous digest has not fully drained, so messages
// shorter than eight bytes are limited by the eight-word output rate.
module rotate_xor_byte_digest (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rxd_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rxd_pkg::out_t  out_data_o
);

  rxd_pkg::in_t        in_q;
  logic                in_valid_q, in_valid_d;
  rxd_pkg::lane_set_t  lanes_q, lanes_d, lanes_next;
  logic [31:0]         pos_q, pos_d, pos_next;
  rxd_pkg::buf_ctrl_t  buf_req, buf_sts;
  logic                in_xfer;
  logic                consume;

  // Input register drains unless a final byte meets a busy buffer
  assign consume    = in_valid_q && (!in_q.final_byte || buf_sts.ready);
  assign in_stall_o = in_valid_q && !consume;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_valid_d = in_xfer ? 1'b1 : (consume ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  // Lane update
  rxd_lane_mix u_mix (
    .lanes_i     (lanes_q),
    .position_i  (pos_q),
    .data_byte_i (in_q.data_byte),
    .lanes_o     (lanes_next),
    .position_o  (pos_next)
  );

  always_comb begin
    lanes_d = lanes_q;
    pos_d   = pos_q;
    if (consume) begin
      if (in_q.final_byte) begin
        lanes_d = rxd_pkg::StartWords;
        pos_d   = '0;
      end else begin
        lanes_d = lanes_next;
        pos_d   = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= rxd_pkg::StartWords;
      pos_q   <= '0;
    end else begin
      lanes_q <= lanes_d;
      pos_q   <= pos_d;
    end
  end

  // Digest output buffer
  assign buf_req.load  = consume && in_q.final_byte;
  assign buf_req.ready = 1'b0;

  rxd_digest_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .words_i     (lanes_next),
    .ctrl_i      (buf_req),
    .ctrl_o      (buf_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Digest words leave in order without gaps in numbering
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_word |=>
      out_valid_o && out_data_o.word_number == $past(out_data_o.word_number) + 1'b1)
    else $error("digest word order broken");

  // A non-final byte never waits on the output side
  a_no_stall_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_q.final_byte |-> !in_stall_o)
    else $error("non-final byte stalled");

  // State restarts after a final byte
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_q.final_byte |=> pos_q == '0 && lanes_q == rxd_pkg::StartWords)
    else $error("state not restarted after digest");

  // A new digest starts at word zero
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_req.load |=> out_valid_o && out_data_o.word_number == '0)
    else $error("digest does not start at word zero");

endmodule
